@@ design/h2rv_pkg.sv @@
package h2rv_pkg;

  // Input actions
  typedef enum logic [2:0] {
    ACT_NAME_CHAR   = 3'd0,
    ACT_VALUE_CHAR  = 3'd1,
    ACT_END_FIELD   = 3'd2,
    ACT_END_BLOCK   = 3'd3,
    ACT_DECODE_FAIL = 3'd4
  } action_t;

  // Result codes, also used as the error latch encoding
  typedef enum logic [1:0] {
    RES_OK          = 2'd0,
    RES_PROTOCOL    = 2'd1,
    RES_COMPRESSION = 2'd2
  } result_t;

  localparam int NUM_NAMES = 6;
  localparam int NAME_POS_W = 5;
  localparam int STATUS_W = 10;

  localparam logic [NAME_POS_W-1:0] NAME_POS_MAX = 5'd31;
  localparam logic [STATUS_W-1:0]   STATUS_LIMIT = 10'd999;
  localparam logic [STATUS_W-1:0]   ACC_BAD      = 10'd1023;
  localparam logic [NUM_NAMES-1:0]  MASK_ALL     = 6'h3F;

  // Tracked name slots
  localparam logic [2:0] NAME_CONNECTION = 3'd0;
  localparam logic [2:0] NAME_KEEP_ALIVE = 3'd1;
  localparam logic [2:0] NAME_PROXY_CONN = 3'd2;
  localparam logic [2:0] NAME_XFER_ENC   = 3'd3;
  localparam logic [2:0] NAME_UPGRADE    = 3'd4;
  localparam logic [2:0] NAME_STATUS     = 3'd5;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef struct packed {
    logic [NUM_NAMES-1:0] mask_nxt;  // match mask after this name character
    logic [NUM_NAMES-1:0] hit;       // full-length match with the current mask
  } name_match_t;

  function automatic logic [NAME_POS_W-1:0] name_len(input logic [2:0] k);
    logic [NAME_POS_W-1:0] len;
    case (k)
      NAME_CONNECTION: len = 5'd10;
      NAME_KEEP_ALIVE: len = 5'd10;
      NAME_PROXY_CONN: len = 5'd16;
      NAME_XFER_ENC:   len = 5'd17;
      NAME_UPGRADE:    len = 5'd7;
      NAME_STATUS:     len = 5'd7;
      default:         len = 5'd0;
    endcase
    return len;
  endfunction

  // Character at position pos of tracked name k; zero beyond the name
  function automatic logic [7:0] name_char(input logic [2:0] k,
                                           input logic [NAME_POS_W-1:0] pos);
    logic [8*17-1:0]       txt;
    logic [NAME_POS_W-1:0] len;
    logic [NAME_POS_W-1:0] idx;
    logic [7:0]            ch;
    case (k)
      NAME_CONNECTION: txt = "connection";
      NAME_KEEP_ALIVE: txt = "keep-alive";
      NAME_PROXY_CONN: txt = "proxy-connection";
      NAME_XFER_ENC:   txt = "transfer-encoding";
      NAME_UPGRADE:    txt = "upgrade";
      NAME_STATUS:     txt = ":status";
      default:         txt = '0;
    endcase
    len = name_len(k);
    idx = len - pos - 5'd1;
    if (pos < len) begin
      ch = txt[8*idx +: 8];
    end else begin
      ch = 8'h00;
    end
    return ch;
  endfunction

endpackage

@@ design/h2rv_if.sv @@
interface h2rv_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] char_byte;
  logic       trailer_block;
  logic       end_stream_pending;

  modport source (output valid, action, char_byte, trailer_block, end_stream_pending,
                  input ready);
  modport sink (input valid, action, char_byte, trailer_block, end_stream_pending,
                output ready);
endinterface

interface h2rv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_code;
  logic [9:0] resp_status;
  logic       stream_done;

  modport source (output valid, result_code, resp_status, stream_done, input ready);
  modport sink (input valid, result_code, resp_status, stream_done, output ready);
endinterface

@@ design/h2rv_name_match.sv @@
module h2rv_name_match import h2rv_pkg::*; (
  input  logic [NAME_POS_W-1:0] name_pos,
  input  logic [7:0]            char_byte,
  input  logic [NUM_NAMES-1:0]  mask,
  output name_match_t           match
);

  always_comb begin
    for (int k = 0; k < NUM_NAMES; k++) begin
      // drop a name once the character differs or the name is already complete
      match.mask_nxt[k] = mask[k] && (name_pos < name_len(3'(k))) &&
                          (name_char(3'(k), name_pos) == char_byte);
      match.hit[k]      = mask[k] && (name_pos == name_len(3'(k)));
    end
  end

endmodule

@@ design/http2_response_header_validator_unit.sv @@
// Checks a decoded HTTP/2 response header or trailer block that arrives one
// character per request, with end-of-field, end-of-block and decode-failure
// markers. Names must be non-empty and lower case; a single :status is the
// only pseudo-header allowed, it must come before any regular field and never
// in trailers; connection, keep-alive, proxy-connection, transfer-encoding and
// upgrade are refused. The :status value is parsed as decimal up to 999. The
// first error is latched (a decode failure always wins) and one result is
// returned per end-of-block request, after which all block state resets. The
// unit takes one request every cycle unless an end-of-block request waits for a
// busy result slot; a result is loaded into the result register by the single
// state update pass when its end-of-block request leaves the input register.
module http2_response_header_validator_unit import h2rv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  h2rv_in_if.sink     in_ch,
  h2rv_out_if.source  out_ch
);

  // Input register
  logic       s1_valid_r;
  action_t    s1_action_r;
  logic [7:0] s1_char_r;
  logic       s1_trailer_r;
  logic       s1_es_r;

  // Block state
  result_t               err_r, err_nxt;
  logic                  pseudo_sec_r, pseudo_sec_nxt;
  logic                  status_seen_r, status_seen_nxt;
  logic [NAME_POS_W-1:0] name_pos_r, name_pos_nxt;
  logic [NUM_NAMES-1:0]  mask_r, mask_nxt;
  logic [STATUS_W-1:0]   acc_r, acc_nxt;
  logic [STATUS_W-1:0]   status_val_r, status_val_nxt;
  logic                  pseudo_name_r, pseudo_name_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  result_t             out_code_r, out_code_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_done_r, out_done_nxt;

  logic        out_free;
  logic        s1_emits;
  logic        s1_fire;
  logic        field_bad;
  logic        forbidden;
  logic [13:0] acc_x10;
  logic [13:0] acc_sum;
  logic        is_digit;
  name_match_t match;

  h2rv_name_match u_match (
    .name_pos  (name_pos_r),
    .char_byte (s1_char_r),
    .mask      (mask_r),
    .match     (match)
  );

  // Advance the held request unless it needs the result slot and that is busy.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_emits     = (s1_action_r == ACT_END_BLOCK);
  assign s1_fire      = s1_valid_r && (!s1_emits || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_fire;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_code = out_code_r;
  assign out_ch.resp_status = out_status_r;
  assign out_ch.stream_done = out_done_r;

  assign is_digit  = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
  assign acc_x10   = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign acc_sum   = acc_x10 + {10'd0, s1_char_r[3:0]};
  assign forbidden = |match.hit[NAME_UPGRADE:NAME_CONNECTION];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Payload of the input register: load on accept only
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action_r  <= action_t'(in_ch.action);
      s1_char_r    <= in_ch.char_byte;
      s1_trailer_r <= in_ch.trailer_block;
      s1_es_r      <= in_ch.end_stream_pending;
    end
  end

  always_comb begin
    err_nxt         = err_r;
    pseudo_sec_nxt  = pseudo_sec_r;
    status_seen_nxt = status_seen_r;
    name_pos_nxt    = name_pos_r;
    mask_nxt        = mask_r;
    acc_nxt         = acc_r;
    status_val_nxt  = status_val_r;
    pseudo_name_nxt = pseudo_name_r;
    field_bad       = 1'b0;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_code_nxt   = out_code_r;
    out_status_nxt = out_status_r;
    out_done_nxt   = out_done_r;

    if (s1_fire) begin
      case (s1_action_r)
        ACT_NAME_CHAR: begin
          if (s1_char_r >= CH_UPPER_A && s1_char_r <= CH_UPPER_Z && err_r == RES_OK) begin
            err_nxt = RES_PROTOCOL;
          end
          if (name_pos_r == '0 && s1_char_r == CH_COLON) begin
            pseudo_name_nxt = 1'b1;
          end
          mask_nxt = match.mask_nxt;
          if (name_pos_r < NAME_POS_MAX) begin
            name_pos_nxt = name_pos_r + 5'd1;
          end
        end
        ACT_VALUE_CHAR: begin
          // hold once the value is known bad or out of range
          if (acc_r <= STATUS_LIMIT) begin
            if (!is_digit || acc_sum > {4'd0, STATUS_LIMIT}) begin
              acc_nxt = ACC_BAD;
            end else begin
              acc_nxt = acc_sum[STATUS_W-1:0];
            end
          end
        end
        ACT_END_FIELD: begin
          if (name_pos_r == '0) begin
            field_bad = 1'b1;
          end else if (pseudo_name_r) begin
            if (s1_trailer_r || !pseudo_sec_r) begin
              field_bad = 1'b1;
            end else if (match.hit[NAME_STATUS]) begin
              if (status_seen_r) begin
                field_bad = 1'b1;
              end else begin
                status_seen_nxt = 1'b1;
                if (acc_r > STATUS_LIMIT) begin
                  field_bad = 1'b1;
                end else if (err_r == RES_OK) begin
                  status_val_nxt = acc_r;
                end
              end
            end else begin
              field_bad = 1'b1;
            end
          end else begin
            // first regular field closes the pseudo-header section
            pseudo_sec_nxt = 1'b0;
            field_bad      = forbidden;
          end
          if (field_bad && err_r == RES_OK) begin
            err_nxt = RES_PROTOCOL;
          end
          name_pos_nxt    = '0;
          mask_nxt        = MASK_ALL;
          acc_nxt         = '0;
          pseudo_name_nxt = 1'b0;
        end
        ACT_END_BLOCK: begin
          out_valid_nxt  = 1'b1;
          out_code_nxt   = err_r;
          out_status_nxt = '0;
          out_done_nxt   = 1'b0;
          if (err_r == RES_OK) begin
            if (s1_trailer_r) begin
              out_done_nxt = 1'b1;
            end else if (!status_seen_r) begin
              out_code_nxt = RES_PROTOCOL;
            end else begin
              out_status_nxt = status_val_r;
              out_done_nxt   = s1_es_r;
            end
          end
          // drop any partial field and return to reset state
          err_nxt         = RES_OK;
          pseudo_sec_nxt  = 1'b1;
          status_seen_nxt = 1'b0;
          status_val_nxt  = '0;
          name_pos_nxt    = '0;
          mask_nxt        = MASK_ALL;
          acc_nxt         = '0;
          pseudo_name_nxt = 1'b0;
        end
        ACT_DECODE_FAIL: begin
          err_nxt = RES_COMPRESSION;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r         <= RES_OK;
      pseudo_sec_r  <= 1'b1;
      status_seen_r <= 1'b0;
      name_pos_r    <= '0;
      mask_r        <= MASK_ALL;
      acc_r         <= '0;
      status_val_r  <= '0;
      pseudo_name_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      err_r         <= err_nxt;
      pseudo_sec_r  <= pseudo_sec_nxt;
      status_seen_r <= status_seen_nxt;
      name_pos_r    <= name_pos_nxt;
      mask_r        <= mask_nxt;
      acc_r         <= acc_nxt;
      status_val_r  <= status_val_nxt;
      pseudo_name_r <= pseudo_name_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r   <= out_code_nxt;
    out_status_r <= out_status_nxt;
    out_done_r   <= out_done_nxt;
  end

`ifndef SYNTHESIS
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_r != RES_OK) |-> (out_status_r == '0 && !out_done_r))
    else $error("error result carries status or done");

  a_decode_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_action_r == ACT_DECODE_FAIL) |=> (err_r == RES_COMPRESSION))
    else $error("decode failure not latched");

  a_block_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_action_r == ACT_END_BLOCK) |=>
      (err_r == RES_OK && pseudo_sec_r && !status_seen_r && name_pos_r == '0 &&
       mask_r == MASK_ALL && out_valid_r))
    else $error("block state not reset at end of block");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    status_val_r <= STATUS_LIMIT)
    else $error("stored status out of range");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_code_r)))
    else $error("result lost while stalled");
`endif

endmodule
